// ===== sv/wrm_pkg.sv =====
// Shared types and constants for the windowed RMS dynamic range core.
// Used by the channel interfaces, the controller, the datapath and the top level.
package wrm_pkg;

  localparam int unsigned SMP_W      = 16;
  localparam int unsigned LVL_W      = 16;
  localparam int unsigned PCT_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [25:0] DB_SCALE = 26'd50504453;
  localparam int unsigned LOG_BIAS = 30 << 16;
  localparam logic [PCT_W-1:0] PCT_ONE = 17'h10000;

  localparam logic [12:0] WIN_LEN_RST  = 13'd1024;
  localparam logic [15:0] HOP_LEN_RST  = 16'd512;
  localparam logic [15:0] FLOOR_RST    = 16'h8800;
  localparam logic [16:0] LOW_PCT_RST  = 17'd6554;
  localparam logic [16:0] HIGH_PCT_RST = 17'd62259;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN,
    REG_HOP_LEN,
    REG_FLOOR_DB,
    REG_LOW_PCT,
    REG_HIGH_PCT
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_UPD,
    ST_CHK,
    ST_LG_LOAD,
    ST_LG_NORM,
    ST_LG_MUL,
    ST_LG_SQR,
    ST_DB_MUL,
    ST_DB_FIN,
    ST_EMIT_LVL,
    ST_PCT,
    ST_RK_LOAD,
    ST_RK_CAP,
    ST_RK_SWEEP,
    ST_RK_NEXT,
    ST_IP_MUL,
    ST_IP_FIN,
    ST_EMIT_SUM
  } st_e;

  typedef struct packed {
    logic accept;
    logic sq;
    logic upd;
    logic lg_load;
    logic lg_norm;
    logic lg_mul;
    logic lg_sqr;
    logic db_mul;
    logic db_fin;
    logic emit_lvl;
    logic pct_mul;
    logic rk_load;
    logic rk_cap;
    logic rk_sweep;
    logic rk_next;
    logic ip_mul;
    logic ip_fin;
    logic emit_sum;
  } cmd_t;

  typedef struct packed {
    logic have;
    logic eoc;
    logic sum_zero;
    logic lg_msb;
    logic lg_last;
    logic lg_sel;
    logic slot_free;
    logic sweep_done;
    logic rank_last;
  } sts_t;

endpackage

// ===== sv/wrm_if.sv =====
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on wrm_pkg for field widths.
interface wrm_smp_if;
  logic                              valid;
  logic                              ready;
  logic signed [wrm_pkg::SMP_W-1:0]  sample;
  logic                              end_of_clip;
  modport source (output valid, sample, end_of_clip, input ready);
  modport sink   (input valid, sample, end_of_clip, output ready);
endinterface

interface wrm_res_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [wrm_pkg::LVL_W-1:0]  window_db;
  logic signed [wrm_pkg::LVL_W-1:0]  low_db;
  logic signed [wrm_pkg::LVL_W-1:0]  high_db;
  logic        [wrm_pkg::LVL_W-1:0]  range_db;
  logic                              overflowed;
  logic                              last;
  modport source (output valid, kind, window_db, low_db, high_db, range_db, overflowed,
                  last, input ready);
  modport sink   (input valid, kind, window_db, low_db, high_db, range_db, overflowed,
                  last, output ready);
endinterface

interface wrm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wrm_pkg::CFG_IDX_W-1:0]       index;
  logic [wrm_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/wrm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module wrm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/wrm_ctrl.sv =====
// Sequencing state machine for the windowed RMS dynamic range core.
// Depends on wrm_pkg; drives the datapath through cmd_t and watches sts_t.
module wrm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  wrm_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output wrm_pkg::cmd_t cmd_o
);

  wrm_pkg::st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      wrm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = wrm_pkg::ST_SQ;
        end
      end
      wrm_pkg::ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = wrm_pkg::ST_UPD;
      end
      wrm_pkg::ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = wrm_pkg::ST_CHK;
      end
      wrm_pkg::ST_CHK: begin
        if (sts_i.have) begin
          state_d = sts_i.sum_zero ? wrm_pkg::ST_DB_FIN : wrm_pkg::ST_LG_LOAD;
        end else begin
          state_d = sts_i.eoc ? wrm_pkg::ST_PCT : wrm_pkg::ST_IDLE;
        end
      end
      wrm_pkg::ST_LG_LOAD: begin
        cmd_o.lg_load = 1'b1;
        state_d       = wrm_pkg::ST_LG_NORM;
      end
      wrm_pkg::ST_LG_NORM: begin
        cmd_o.lg_norm = 1'b1;
        if (sts_i.lg_msb) begin
          state_d = wrm_pkg::ST_LG_MUL;
        end
      end
      wrm_pkg::ST_LG_MUL: begin
        cmd_o.lg_mul = 1'b1;
        state_d      = wrm_pkg::ST_LG_SQR;
      end
      wrm_pkg::ST_LG_SQR: begin
        cmd_o.lg_sqr = 1'b1;
        if (!sts_i.lg_last) begin
          state_d = wrm_pkg::ST_LG_MUL;
        end else if (sts_i.lg_sel) begin
          state_d = wrm_pkg::ST_DB_MUL;
        end else begin
          state_d = wrm_pkg::ST_LG_LOAD;
        end
      end
      wrm_pkg::ST_DB_MUL: begin
        cmd_o.db_mul = 1'b1;
        state_d      = wrm_pkg::ST_DB_FIN;
      end
      wrm_pkg::ST_DB_FIN: begin
        cmd_o.db_fin = 1'b1;
        state_d      = wrm_pkg::ST_EMIT_LVL;
      end
      wrm_pkg::ST_EMIT_LVL: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_lvl = 1'b1;
          state_d        = sts_i.eoc ? wrm_pkg::ST_PCT : wrm_pkg::ST_IDLE;
        end
      end
      wrm_pkg::ST_PCT: begin
        cmd_o.pct_mul = 1'b1;
        state_d       = wrm_pkg::ST_RK_LOAD;
      end
      wrm_pkg::ST_RK_LOAD: begin
        cmd_o.rk_load = 1'b1;
        state_d       = wrm_pkg::ST_RK_CAP;
      end
      wrm_pkg::ST_RK_CAP: begin
        cmd_o.rk_cap = 1'b1;
        state_d      = wrm_pkg::ST_RK_SWEEP;
      end
      wrm_pkg::ST_RK_SWEEP: begin
        cmd_o.rk_sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = wrm_pkg::ST_RK_NEXT;
        end
      end
      wrm_pkg::ST_RK_NEXT: begin
        cmd_o.rk_next = 1'b1;
        state_d       = sts_i.rank_last ? wrm_pkg::ST_IP_MUL : wrm_pkg::ST_RK_LOAD;
      end
      wrm_pkg::ST_IP_MUL: begin
        cmd_o.ip_mul = 1'b1;
        state_d      = wrm_pkg::ST_IP_FIN;
      end
      wrm_pkg::ST_IP_FIN: begin
        cmd_o.ip_fin = 1'b1;
        state_d      = wrm_pkg::ST_EMIT_SUM;
      end
      wrm_pkg::ST_EMIT_SUM: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_sum = 1'b1;
          state_d        = wrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/wrm_dp.sv =====
// Datapath: config registers, sliding sum of squares, log2/dB unit, level store,
// rank-based percentile selection and the output register. Depends on wrm_pkg, wrm_ram.
module wrm_dp #(
  parameter int unsigned WINDOW_MAX  = 4096,
  parameter int unsigned MAX_WINDOWS = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wrm_pkg::cmd_t                         cmd_i,
  output wrm_pkg::sts_t                         sts_o,
  input  logic signed [wrm_pkg::SMP_W-1:0]      sample_i,
  input  logic                                  eoc_i,
  input  logic                                  cfg_we_i,
  input  logic [wrm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [wrm_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic                                  out_kind_o,
  output logic signed [wrm_pkg::LVL_W-1:0]      out_window_db_o,
  output logic signed [wrm_pkg::LVL_W-1:0]      out_low_db_o,
  output logic signed [wrm_pkg::LVL_W-1:0]      out_high_db_o,
  output logic [wrm_pkg::LVL_W-1:0]             out_range_db_o,
  output logic                                  out_overflowed_o,
  output logic                                  out_last_o
);

  localparam int unsigned RA_W   = $clog2(WINDOW_MAX);
  localparam int unsigned WW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned RI_W   = $clog2(2 * WINDOW_MAX);
  localparam int unsigned SUM_W  = 31 + RA_W;
  localparam int unsigned P_W    = $clog2(SUM_W);
  localparam int unsigned L_W    = P_W + 16;
  localparam int unsigned D_W    = L_W + 2;
  localparam int unsigned M_W    = L_W + 1;
  localparam int unsigned DBP_W  = M_W + 26;
  localparam int unsigned V_W    = DBP_W - 31;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned LA_W   = $clog2(MAX_WINDOWS);
  localparam int unsigned POS_W  = 17 + CNT_W;

  // configuration
  logic [12:0]        win_len_q;
  logic [15:0]        hop_len_q;
  logic signed [15:0] floor_q;
  logic [16:0]        low_pct_q, high_pct_q;

  // per sample
  logic signed [15:0] sample_q;
  logic               eoc_q;
  logic [WW-1:0]      win_q;
  logic [15:0]        hop_q;
  logic [RA_W-1:0]    ring_pos_q;
  logic [31:0]        seen_q;
  logic [15:0]        hop_ph_q;
  logic [SUM_W-1:0]   sum_q;
  logic [30:0]        sq_new_q, sq_old_q;
  logic               have_q;
  logic [WW-1:0]      n_q;

  // log2 / dB unit
  logic [SUM_W-1:0]   lg_t_q;
  logic [P_W-1:0]     lg_p_q;
  logic [30:0]        lg_m_q;
  logic [15:0]        lg_f_q;
  logic [3:0]         lg_i_q;
  logic [61:0]        lg_prod_q;
  logic               lg_sel_q;
  logic [L_W-1:0]     l_sum_q, l_n_q;
  logic [DBP_W-1:0]   db_prod_q;
  logic               db_neg_q;
  logic signed [15:0] level_q;

  // level store and percentiles
  logic [CNT_W-1:0]   cnt_q;
  logic               ovf_q;
  logic [POS_W-1:0]   pos_lo_q, pos_hi_q;
  logic [LA_W-1:0]    j_q;
  logic [CNT_W-1:0]   i_q;
  logic               rv_q;
  logic signed [15:0] vj_q;
  logic [CNT_W-1:0]   lt_q, le_q;
  logic signed [15:0] a_lo_q, b_lo_q, a_hi_q, b_hi_q;
  logic [32:0]        ip_lo_q, ip_hi_q;
  logic signed [15:0] lo_db_q, hi_db_q;

  // output register
  logic               out_valid_q, out_kind_q, out_ovf_q, out_last_q;
  logic signed [15:0] out_win_q, out_lo_q, out_hi_q;
  logic [15:0]        out_rng_q;

  // combinational
  logic [16:0]        win_clip;
  logic [WW-1:0]      win_eff, win_use;
  logic [15:0]        hop_eff;
  logic [RA_W-1:0]    pos_use;
  logic [RI_W-1:0]    ridx_sum, ridx;
  logic [15:0]        ring_rdata, lvl_rdata;
  logic signed [31:0] sq_new_w, sq_old_w;
  logic [31:0]        seen_n;
  logic [16:0]        hop_p1;
  logic [31:0]        mm;
  logic [15:0]        lg_f_n;
  logic signed [D_W-1:0] db_d;
  logic [M_W-1:0]     db_mag;
  logic [DBP_W:0]     db_rnd;
  logic [V_W-1:0]     db_vu;
  logic signed [V_W:0] db_sv;
  logic signed [15:0] db_sat, db_lvl;
  logic [16:0]        lo_pct_c, hi_pct_c;
  logic [CNT_W-1:0]   klo, khi, klo1, khi1;
  logic [CNT_W-1:0]   cnt_m1;
  logic signed [16:0] diff_lo, diff_hi, rng_w;
  logic [33:0]        rnd_lo, rnd_hi;
  logic               slot_free;
  logic               lvl_we;
  logic [LA_W-1:0]    lvl_raddr;

  assign win_clip = (win_len_q == '0) ? 17'd1 :
                    (32'(win_len_q) > WINDOW_MAX) ? 17'(WINDOW_MAX) : 17'(win_len_q);
  assign win_eff  = WW'(win_clip);
  assign hop_eff  = (hop_len_q == '0) ? 16'd1 : hop_len_q;
  assign win_use  = (seen_q == '0) ? win_eff : win_q;
  assign pos_use  = (seen_q == '0) ? '0 : ring_pos_q;

  assign ridx_sum = RI_W'(pos_use) + RI_W'(WINDOW_MAX) - RI_W'(win_use);
  assign ridx     = (ridx_sum >= RI_W'(WINDOW_MAX)) ? ridx_sum - RI_W'(WINDOW_MAX) : ridx_sum;

  assign sq_new_w = sample_q * sample_q;
  assign sq_old_w = $signed(ring_rdata) * $signed(ring_rdata);
  assign seen_n   = (seen_q == '1) ? seen_q : seen_q + 32'd1;
  assign hop_p1   = {1'b0, hop_ph_q} + 17'd1;

  assign mm     = lg_prod_q[61:30];
  assign lg_f_n = {lg_f_q[14:0], mm[31]};

  assign db_d   = $signed({2'b00, l_sum_q}) - $signed({2'b00, l_n_q})
                - $signed(D_W'(wrm_pkg::LOG_BIAS));
  assign db_mag = db_d[D_W-1] ? M_W'(-db_d) : M_W'(db_d);
  assign db_rnd = {1'b0, db_prod_q} + (DBP_W+1)'(33'h0_8000_0000);
  assign db_vu  = db_rnd[DBP_W:32];
  assign db_sv  = db_neg_q ? -$signed({1'b0, db_vu}) : $signed({1'b0, db_vu});
  assign db_sat = (db_sv > $signed((V_W+1)'(32767)))  ? 16'sd32767 :
                  (db_sv < -$signed((V_W+1)'(32768))) ? -16'sd32768 : 16'(db_sv);
  assign db_lvl = (sum_q == '0 || db_sat < floor_q) ? floor_q : db_sat;

  assign lo_pct_c = (low_pct_q[16] && low_pct_q[15:0] != '0) ? wrm_pkg::PCT_ONE : low_pct_q;
  assign hi_pct_c = (high_pct_q[16] && high_pct_q[15:0] != '0) ? wrm_pkg::PCT_ONE : high_pct_q;
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign klo      = pos_lo_q[16 +: CNT_W];
  assign khi      = pos_hi_q[16 +: CNT_W];
  assign klo1     = klo + CNT_W'(1);
  assign khi1     = khi + CNT_W'(1);

  assign diff_lo = {b_lo_q[15], b_lo_q} - {a_lo_q[15], a_lo_q};
  assign diff_hi = {b_hi_q[15], b_hi_q} - {a_hi_q[15], a_hi_q};
  assign rnd_lo  = {1'b0, ip_lo_q} + 34'd32768;
  assign rnd_hi  = {1'b0, ip_hi_q} + 34'd32768;
  assign rng_w   = {hi_db_q[15], hi_db_q} - {lo_db_q[15], lo_db_q};

  assign slot_free = !out_valid_q || out_ready_i;
  assign lvl_we    = cmd_i.emit_lvl && (cnt_q < CNT_W'(MAX_WINDOWS));
  assign lvl_raddr = cmd_i.rk_load ? j_q : i_q[LA_W-1:0];

  wrm_ram #(.WIDTH(16), .DEPTH(WINDOW_MAX)) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (ring_pos_q),
    .wdata_i (sample_q),
    .raddr_i (ridx[RA_W-1:0]),
    .rdata_o (ring_rdata)
  );

  wrm_ram #(.WIDTH(16), .DEPTH(MAX_WINDOWS)) u_levels (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (cnt_q[LA_W-1:0]),
    .wdata_i (level_q),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  // control and clip state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= wrm_pkg::WIN_LEN_RST;
      hop_len_q   <= wrm_pkg::HOP_LEN_RST;
      floor_q     <= wrm_pkg::FLOOR_RST;
      low_pct_q   <= wrm_pkg::LOW_PCT_RST;
      high_pct_q  <= wrm_pkg::HIGH_PCT_RST;
      win_q       <= '0;
      hop_q       <= '0;
      ring_pos_q  <= '0;
      seen_q      <= '0;
      hop_ph_q    <= '0;
      sum_q       <= '0;
      have_q      <= 1'b0;
      n_q         <= '0;
      eoc_q       <= 1'b0;
      lg_sel_q    <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wrm_pkg::REG_WINDOW_LEN: win_len_q  <= cfg_data_i[12:0];
          wrm_pkg::REG_HOP_LEN:    hop_len_q  <= cfg_data_i[15:0];
          wrm_pkg::REG_FLOOR_DB:   floor_q    <= cfg_data_i[15:0];
          wrm_pkg::REG_LOW_PCT:    low_pct_q  <= cfg_data_i;
          wrm_pkg::REG_HIGH_PCT:   high_pct_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        eoc_q      <= eoc_i;
        win_q      <= win_use;
        ring_pos_q <= pos_use;
        if (seen_q == '0) begin
          hop_q    <= hop_eff;
          hop_ph_q <= '0;
        end
      end
      if (cmd_i.upd) begin
        sum_q      <= sum_q + SUM_W'(sq_new_q)
                    - ((seen_q >= 32'(win_q)) ? SUM_W'(sq_old_q) : '0);
        seen_q     <= seen_n;
        ring_pos_q <= (32'(ring_pos_q) == WINDOW_MAX - 1) ? '0 : ring_pos_q + RA_W'(1);
        lg_sel_q   <= 1'b0;
        if (seen_n >= 32'(win_q)) begin
          have_q   <= (hop_ph_q == '0);
          n_q      <= win_q;
          hop_ph_q <= (hop_p1 >= {1'b0, hop_q}) ? '0 : hop_p1[15:0];
        end else begin
          have_q <= eoc_q;
          n_q    <= WW'(seen_n);
        end
      end
      if (cmd_i.lg_sqr && lg_i_q == 4'd15) begin
        lg_sel_q <= !lg_sel_q;
      end
      if (cmd_i.emit_lvl) begin
        if (lvl_we) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.emit_lvl || cmd_i.emit_sum) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit_sum) begin
        seen_q     <= '0;
        hop_ph_q   <= '0;
        sum_q      <= '0;
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
        ring_pos_q <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.sq) begin
      sq_new_q <= sq_new_w[30:0];
      sq_old_q <= sq_old_w[30:0];
    end
    if (cmd_i.lg_load) begin
      lg_t_q <= lg_sel_q ? SUM_W'(n_q) : sum_q;
      lg_p_q <= P_W'(SUM_W - 1);
    end
    if (cmd_i.lg_norm) begin
      if (!lg_t_q[SUM_W-1]) begin
        lg_t_q <= {lg_t_q[SUM_W-2:0], 1'b0};
        lg_p_q <= lg_p_q - P_W'(1);
      end else begin
        lg_m_q <= lg_t_q[SUM_W-1 -: 31];
        lg_f_q <= '0;
        lg_i_q <= '0;
      end
    end
    if (cmd_i.lg_mul) begin
      lg_prod_q <= lg_m_q * lg_m_q;
    end
    if (cmd_i.lg_sqr) begin
      lg_m_q <= mm[31] ? mm[31:1] : mm[30:0];
      lg_f_q <= lg_f_n;
      lg_i_q <= lg_i_q + 4'd1;
      if (lg_i_q == 4'd15) begin
        if (lg_sel_q) begin
          l_n_q <= {lg_p_q, lg_f_n};
        end else begin
          l_sum_q <= {lg_p_q, lg_f_n};
        end
      end
    end
    if (cmd_i.db_mul) begin
      db_prod_q <= DBP_W'(db_mag) * DBP_W'(wrm_pkg::DB_SCALE);
      db_neg_q  <= db_d[D_W-1];
    end
    if (cmd_i.db_fin) begin
      level_q <= db_lvl;
    end
    if (cmd_i.pct_mul) begin
      pos_lo_q <= POS_W'(lo_pct_c) * POS_W'(cnt_m1);
      pos_hi_q <= POS_W'(hi_pct_c) * POS_W'(cnt_m1);
      j_q      <= '0;
    end
    if (cmd_i.rk_cap) begin
      vj_q <= lvl_rdata;
      i_q  <= '0;
      rv_q <= 1'b0;
      lt_q <= '0;
      le_q <= '0;
    end
    if (cmd_i.rk_sweep) begin
      if (i_q < cnt_q) begin
        i_q  <= i_q + CNT_W'(1);
        rv_q <= 1'b1;
      end else begin
        rv_q <= 1'b0;
      end
      if (rv_q) begin
        if ($signed(lvl_rdata) < vj_q) begin
          lt_q <= lt_q + CNT_W'(1);
        end
        if ($signed(lvl_rdata) <= vj_q) begin
          le_q <= le_q + CNT_W'(1);
        end
      end
    end
    if (cmd_i.rk_next) begin
      if (lt_q <= klo && klo < le_q) begin
        a_lo_q <= vj_q;
      end
      if (lt_q <= klo1 && klo1 < le_q) begin
        b_lo_q <= vj_q;
      end
      if (lt_q <= khi && khi < le_q) begin
        a_hi_q <= vj_q;
      end
      if (lt_q <= khi1 && khi1 < le_q) begin
        b_hi_q <= vj_q;
      end
      j_q <= j_q + LA_W'(1);
    end
    if (cmd_i.ip_mul) begin
      ip_lo_q <= 33'(diff_lo[16:0]) * 33'(pos_lo_q[15:0]);
      ip_hi_q <= 33'(diff_hi[16:0]) * 33'(pos_hi_q[15:0]);
    end
    if (cmd_i.ip_fin) begin
      lo_db_q <= (pos_lo_q[15:0] == '0) ? a_lo_q : a_lo_q + $signed(rnd_lo[31:16]);
      hi_db_q <= (pos_hi_q[15:0] == '0) ? a_hi_q : a_hi_q + $signed(rnd_hi[31:16]);
    end
    if (cmd_i.emit_lvl) begin
      out_kind_q <= 1'b0;
      out_win_q  <= level_q;
      out_lo_q   <= '0;
      out_hi_q   <= '0;
      out_rng_q  <= '0;
      out_ovf_q  <= 1'b0;
      out_last_q <= !eoc_q;
    end
    if (cmd_i.emit_sum) begin
      out_kind_q <= 1'b1;
      out_win_q  <= '0;
      out_lo_q   <= lo_db_q;
      out_hi_q   <= hi_db_q;
      out_rng_q  <= rng_w[16] ? '0 : rng_w[15:0];
      out_ovf_q  <= ovf_q;
      out_last_q <= 1'b1;
    end
  end

  assign sts_o.have       = have_q;
  assign sts_o.eoc        = eoc_q;
  assign sts_o.sum_zero   = (sum_q == '0);
  assign sts_o.lg_msb     = lg_t_q[SUM_W-1];
  assign sts_o.lg_last    = (lg_i_q == 4'd15);
  assign sts_o.lg_sel     = lg_sel_q;
  assign sts_o.slot_free  = slot_free;
  assign sts_o.sweep_done = (i_q == cnt_q) && !rv_q;
  assign sts_o.rank_last  = (CNT_W'(j_q) == cnt_m1);

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_kind_q;
  assign out_window_db_o  = out_win_q;
  assign out_low_db_o     = out_lo_q;
  assign out_high_db_o    = out_hi_q;
  assign out_range_db_o   = out_rng_q;
  assign out_overflowed_o = out_ovf_q;
  assign out_last_o       = out_last_q;

endmodule

// ===== sv/windowed_rms_dynamic_range_core.sv =====
// Windowed RMS level meter with percentile dynamic range, top level.
// A sample without a level is squared and added to the sliding sum; with a level it also
// passes the shared log2 unit (normalize one bit a cycle, 16 square-and-shift steps).
// At clip end a rank pass over the level store selects the low and high percentiles.
// Reset restores register defaults and clears clip state; the sample ring and level
// store are not cleared. Depends on wrm_pkg, wrm_if, wrm_ram, wrm_ctrl, wrm_dp.
module windowed_rms_dynamic_range_core #(
  parameter int unsigned WINDOW_MAX  = 4096,
  parameter int unsigned MAX_WINDOWS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wrm_smp_if.sink   smp_i,
  wrm_res_if.source res_o,
  wrm_cfg_if.sink   cfg_i
);

  wrm_pkg::cmd_t cmd;
  wrm_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  wrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .sts_i      (sts),
    .in_ready_o (smp_i.ready),
    .cmd_o      (cmd)
  );

  wrm_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (smp_i.sample),
    .eoc_i            (smp_i.end_of_clip),
    .cfg_we_i         (cfg_i.valid),
    .cfg_idx_i        (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .out_kind_o       (res_o.kind),
    .out_window_db_o  (res_o.window_db),
    .out_low_db_o     (res_o.low_db),
    .out_high_db_o    (res_o.high_db),
    .out_range_db_o   (res_o.range_db),
    .out_overflowed_o (res_o.overflowed),
    .out_last_o       (res_o.last)
  );

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_lvl || cmd.emit_sum) |-> (!res_o.valid || res_o.ready))
    else $error("result loaded over a pending result");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_i.valid && smp_i.ready) |=> (cmd.sq && !smp_i.ready))
    else $error("accepted item not processed");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_sum |=> (res_o.valid && res_o.kind && res_o.last))
    else $error("summary result malformed");

endmodule
